// ===== hw/rtl/trd_pkg.sv =====
`default_nettype none

package trd_pkg;

   localparam int unsigned DEFAULT_MAJOR_BINS = 256;
   localparam int unsigned HDR_BYTES          = 12;
   localparam int unsigned FIFO_DEPTH         = 4;

   localparam logic [15:0] ROLL_MAJOR = 16'h00a8;
   localparam logic [31:0] ROLL_MINOR = 32'h0000_0001;
   localparam logic [7:0]  CHAR_QUOTE = 8'h22;
   localparam logic [7:0]  CHAR_SPACE = 8'h20;
   localparam logic [7:0]  CHAR_SUB   = 8'h5f;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_WORD   = 2'd1,
      KIND_CHAR   = 2'd2,
      KIND_STRLEN = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      RTYPE_FIXED  = 2'd0,
      RTYPE_STRING = 2'd1,
      RTYPE_MIXED  = 2'd2,
      RTYPE_OTHER  = 2'd3
   } rtype_type;

   typedef struct packed {
      kind_type     kind;
      logic [1:0]   record_type;
      logic [15:0]  major_code;
      logic [31:0]  minor_code;
      logic         entry_exit;
      logic [63:0]  time_delta;
      logic [31:0]  value;
      logic [7:0]   field_index;
      logic [31:0]  major_tally;
      logic         rollover;
      logic         record_end;
   } rsp_type;

   function automatic logic [7:0] sat8(input logic [7:0] v);
      sat8 = (v == 8'hff) ? v : v + 8'd1;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/trd_req_if.sv =====
`default_nettype none

interface trd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/trd_rsp_if.sv =====
`default_nettype none

interface trd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [1:0]  record_type;
   logic [15:0] major_code;
   logic [31:0] minor_code;
   logic        entry_exit;
   logic [63:0] time_delta;
   logic [31:0] value;
   logic [7:0]  field_index;
   logic [31:0] major_tally;
   logic        rollover;
   logic        record_end;

   modport source (output valid, output kind, output record_type, output major_code,
                   output minor_code, output entry_exit, output time_delta, output value,
                   output field_index, output major_tally, output rollover,
                   output record_end, input ready);
   modport sink   (input valid, input kind, input record_type, input major_code,
                   input minor_code, input entry_exit, input time_delta, input value,
                   input field_index, input major_tally, input rollover,
                   input record_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/trace_record_deframer.sv =====
`default_nettype none

// Trace record deframer: takes one byte of a big-endian hook record stream per
// req transaction and produces header, fixed word, string length and string
// character transactions on rsp. Every byte is handled in the cycle it is
// accepted, so one byte per cycle is sustained while rsp keeps up; a byte can
// yield up to two results (header plus payload word 0), which drain through a
// four-entry output queue that parts the two sides. req_ready drops while
// fewer than two queue slots are free. After reset the histogram memory is
// cleared one entry per cycle, all MAJOR_BINS + 1 entries, with req_ready low;
// csr writes are taken at any time. skip_count should be written while idle.
module trace_record_deframer #(
   parameter int unsigned MAJOR_BINS = trd_pkg::DEFAULT_MAJOR_BINS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   trd_req_if.sink          req_chan,
   trd_rsp_if.source        rsp_chan,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);

   localparam int unsigned BIN_W   = $clog2(MAJOR_BINS + 1);
   localparam int unsigned PTR_W   = $clog2(trd_pkg::FIFO_DEPTH);
   localparam int unsigned CNT_W   = PTR_W + 1;

   // ---------------- configuration ----------------
   logic [31:0] skip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= '0;
      end else if (csr_wr_en) begin
         skip_ff <= csr_wr_data;
      end
   end

   // ---------------- parse state ----------------
   logic [15:0] offset_ff, offset_in;
   logic [15:0] len_ff, len_in;
   logic [1:0]  type_ff, type_in;
   logic [15:0] major_ff, major_in;
   logic [31:0] minor_ff, minor_in;
   logic [31:0] low_ff, low_in;
   logic [31:0] high_ff, high_in;
   logic [63:0] first_ff, first_in;
   logic        started_ff, started_in;
   logic [31:0] counter_ff, counter_in;
   logic [31:0] fixed_ff, fixed_in;
   logic [31:0] string_ff, string_in;
   logic [1:0]  pad_ff, pad_in;
   logic [31:0] shift_ff, shift_in;
   logic [7:0]  word_ord_ff, word_ord_in;
   logic [7:0]  str_ord_ff, str_ord_in;

   // histogram update pipeline
   logic             clr_ff, clr_in;
   logic [BIN_W-1:0] clr_idx_ff, clr_idx_in;
   logic             upd_ff;
   logic [BIN_W-1:0] bin_ff;
   logic [31:0]      hist_rd_ff;
   logic [31:0]      tally_ff;

   // output queue
   trd_pkg::rsp_type fifo_ff [trd_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff;

   logic        req_fire, rsp_fire;
   logic [7:0]  b;
   logic [15:0] p;
   logic        skip, roll_now, last;
   logic [16:0] p_inc;
   logic        hdr_fire, hdr_roll, hdr_end;
   logic        pay_fire, pay_end;
   trd_pkg::kind_type pay_kind;
   logic [31:0] pay_value;
   logic [7:0]  pay_index;
   logic [31:0] w, sl_new;
   logic [7:0]  c;
   logic        field, delayed;
   logic [15:0] len_raw;
   logic [63:0] now;
   trd_pkg::rsp_type base, r0, r1;
   logic        v0, v1;
   logic [CNT_W-1:0] push_cnt;
   logic [BIN_W-1:0] bin_in;
   logic [31:0] tally_next;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign b        = req_chan.stream_byte;
   assign p        = offset_ff;
   assign skip     = counter_ff < skip_ff;
   assign roll_now = (major_ff == trd_pkg::ROLL_MAJOR) && (minor_ff == trd_pkg::ROLL_MINOR);
   assign p_inc    = {1'b0, p} + 17'd1;
   assign last     = p_inc >= {1'b0, len_ff};

   always_comb begin
      offset_in   = offset_ff;
      len_in      = len_ff;
      type_in     = type_ff;
      major_in    = major_ff;
      minor_in    = minor_ff;
      low_in      = low_ff;
      high_in     = high_ff;
      first_in    = first_ff;
      started_in  = started_ff;
      counter_in  = counter_ff;
      fixed_in    = fixed_ff;
      string_in   = string_ff;
      pad_in      = pad_ff;
      shift_in    = shift_ff;
      word_ord_in = word_ord_ff;
      str_ord_in  = str_ord_ff;
      hdr_fire    = 1'b0;
      hdr_roll    = 1'b0;
      hdr_end     = 1'b0;
      pay_fire    = 1'b0;
      pay_end     = 1'b0;
      pay_kind    = trd_pkg::KIND_WORD;
      pay_value   = '0;
      pay_index   = '0;
      w           = '0;
      sl_new      = '0;
      c           = '0;
      field       = 1'b0;
      delayed     = 1'b0;
      len_raw     = '0;

      if (req_fire) begin
         if (p < 16'(trd_pkg::HDR_BYTES)) begin
            shift_in = {shift_ff[23:0], b};
            case (p[3:0])
               4'd0: begin
                  fixed_in    = '0;
                  string_in   = '0;
                  pad_in      = '0;
                  word_ord_in = '0;
                  str_ord_in  = '0;
               end
               4'd1: begin
                  type_in = shift_in[1:0];
                  len_raw = {shift_in[15:2], 2'b00};
                  len_in  = (len_raw < 16'(trd_pkg::HDR_BYTES)) ?
                            16'(trd_pkg::HDR_BYTES) : len_raw;
               end
               4'd3: major_in = shift_in[15:0];
               4'd7: minor_in = shift_in;
               4'd11: begin
                  // header waits for word 0 on rollover and mixed records of 16 bytes or more
                  delayed  = (len_ff >= 16'd16) &&
                             (type_ff == trd_pkg::RTYPE_MIXED || roll_now);
                  low_in   = shift_in;
                  fixed_in = (type_ff == trd_pkg::RTYPE_FIXED) ?
                             32'((len_ff - 16'(trd_pkg::HDR_BYTES)) >> 2) : '0;
                  if (!delayed) begin
                     hdr_fire = 1'b1;
                     hdr_end  = skip || (len_ff <= 16'(trd_pkg::HDR_BYTES));
                  end
               end
               default: ;
            endcase
         end else if (string_ff != '0) begin
            c = (b == trd_pkg::CHAR_QUOTE || b == trd_pkg::CHAR_SPACE) ?
                trd_pkg::CHAR_SUB : b;
            sl_new    = string_ff - 32'd1;
            string_in = sl_new;
            pay_end   = last || ((sl_new == '0) &&
                        ({1'b0, p_inc} + 18'(pad_ff) >= {2'b00, len_ff}));
            if (!skip) begin
               pay_fire  = 1'b1;
               pay_kind  = trd_pkg::KIND_CHAR;
               pay_value = {24'd0, c};
               pay_index = str_ord_ff;
            end
            if (sl_new == '0) begin
               str_ord_in = trd_pkg::sat8(str_ord_ff);
            end
         end else if (pad_ff != '0) begin
            pad_in = pad_ff - 2'd1;
         end else begin
            shift_in = {shift_ff[23:0], b};
            if (p[1:0] == 2'd3) begin
               w     = shift_in;
               field = 1'b1;
               if (p == 16'd15 && (type_ff == trd_pkg::RTYPE_MIXED || roll_now)) begin
                  if (roll_now) begin
                     high_in = w;
                  end
                  if (type_ff == trd_pkg::RTYPE_MIXED) begin
                     fixed_in = w;
                     field    = 1'b0;
                  end
                  hdr_fire = 1'b1;
                  hdr_roll = roll_now;
                  hdr_end  = skip ? 1'b1 : (field ? 1'b0 : last);
               end
               if (field) begin
                  if (fixed_ff != '0) begin
                     fixed_in = fixed_ff - 32'd1;
                     if (!skip) begin
                        pay_fire    = 1'b1;
                        pay_kind    = trd_pkg::KIND_WORD;
                        pay_value   = w;
                        pay_index   = word_ord_ff;
                        pay_end     = last;
                        word_ord_in = trd_pkg::sat8(word_ord_ff);
                     end
                  end else begin
                     string_in = w;
                     pad_in    = 2'(2'd0 - w[1:0]);
                     if (!skip) begin
                        pay_fire  = 1'b1;
                        pay_kind  = trd_pkg::KIND_STRLEN;
                        pay_value = w;
                        pay_index = str_ord_ff;
                        pay_end   = last;
                        if (w == '0) begin
                           str_ord_in = trd_pkg::sat8(str_ord_ff);
                        end
                     end
                  end
               end
            end
         end

         // record boundary
         if (p >= 16'd11 && last) begin
            if (counter_ff != 32'hffff_ffff) begin
               counter_in = counter_ff + 32'd1;
            end
            offset_in = '0;
            string_in = '0;
            pad_in    = '0;
         end else begin
            offset_in = p_inc[15:0];
         end
      end

      // header time base; the first header ever fixes the reference
      now = {high_in, low_in};
      if (hdr_fire && !started_ff) begin
         started_in = 1'b1;
         first_in   = now;
      end
   end

   // result assembly
   always_comb begin
      base             = '0;
      base.record_type = type_ff;
      base.major_code  = major_ff;
      base.minor_code  = minor_ff;
      base.entry_exit  = minor_ff[31];

      r0 = base;
      r1 = base;
      v0 = 1'b0;
      v1 = 1'b0;
      if (hdr_fire) begin
         v0             = 1'b1;
         r0.kind        = trd_pkg::KIND_HEADER;
         r0.value       = {16'd0, len_ff};
         r0.time_delta  = now - first_in;
         r0.major_tally = tally_ff;
         r0.rollover    = hdr_roll;
         r0.record_end  = hdr_end;
         if (pay_fire) begin
            v1             = 1'b1;
            r1.kind        = pay_kind;
            r1.value       = pay_value;
            r1.field_index = pay_index;
            r1.record_end  = pay_end;
         end
      end else if (pay_fire) begin
         v0             = 1'b1;
         r0.kind        = pay_kind;
         r0.value       = pay_value;
         r0.field_index = pay_index;
         r0.record_end  = pay_end;
      end
      push_cnt = CNT_W'(v0) + CNT_W'(v1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= '0;
         len_ff      <= '0;
         type_ff     <= '0;
         major_ff    <= '0;
         minor_ff    <= '0;
         low_ff      <= '0;
         high_ff     <= '0;
         first_ff    <= '0;
         started_ff  <= 1'b0;
         counter_ff  <= '0;
         fixed_ff    <= '0;
         string_ff   <= '0;
         pad_ff      <= '0;
         shift_ff    <= '0;
         word_ord_ff <= '0;
         str_ord_ff  <= '0;
      end else begin
         offset_ff   <= offset_in;
         len_ff      <= len_in;
         type_ff     <= type_in;
         major_ff    <= major_in;
         minor_ff    <= minor_in;
         low_ff      <= low_in;
         high_ff     <= high_in;
         first_ff    <= first_in;
         started_ff  <= started_in;
         counter_ff  <= counter_in;
         fixed_ff    <= fixed_in;
         string_ff   <= string_in;
         pad_ff      <= pad_in;
         shift_ff    <= shift_in;
         word_ord_ff <= word_ord_in;
         str_ord_ff  <= str_ord_in;
      end
   end

   // ---------------- major histogram ----------------
   // Read at the major's last byte, increment and write back in the following cycle.
   // The next read is at least a full header away, so no bypass is needed.
   logic [31:0] hist_mem [MAJOR_BINS + 1];

   assign bin_in = ({1'b0, major_in} < 17'(MAJOR_BINS)) ?
                   BIN_W'(major_in) : BIN_W'(MAJOR_BINS);
   assign tally_next = (hist_rd_ff == 32'hffff_ffff) ? hist_rd_ff : hist_rd_ff + 32'd1;
   assign clr_in     = clr_ff && (clr_idx_ff != BIN_W'(MAJOR_BINS));
   assign clr_idx_in = clr_idx_ff + BIN_W'(1);

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         hist_mem[clr_idx_ff] <= '0;
      end else if (upd_ff) begin
         hist_mem[bin_ff] <= tally_next;
      end
      hist_rd_ff <= hist_mem[bin_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_idx_ff <= '0;
         upd_ff     <= 1'b0;
      end else begin
         clr_ff     <= clr_in;
         clr_idx_ff <= clr_idx_in;
         upd_ff     <= req_fire && (p == 16'd3);
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      if (upd_ff) begin
         tally_ff <= tally_next;
      end
   end

   // ---------------- output queue ----------------
   always_ff @(posedge clock) begin
      if (v0) begin
         fifo_ff[wr_ptr_ff] <= r0;
      end
      if (v1) begin
         fifo_ff[wr_ptr_ff + PTR_W'(1)] <= r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(push_cnt);
         rd_ptr_ff <= rd_ptr_ff + PTR_W'(rsp_fire);
         cnt_ff    <= cnt_ff + push_cnt - CNT_W'(rsp_fire);
      end
   end

   assign req_chan.ready      = !clr_ff &&
                                (cnt_ff <= CNT_W'(trd_pkg::FIFO_DEPTH - 2));
   assign rsp_chan.valid      = cnt_ff != '0;
   assign rsp_chan.kind       = fifo_ff[rd_ptr_ff].kind;
   assign rsp_chan.record_type = fifo_ff[rd_ptr_ff].record_type;
   assign rsp_chan.major_code = fifo_ff[rd_ptr_ff].major_code;
   assign rsp_chan.minor_code = fifo_ff[rd_ptr_ff].minor_code;
   assign rsp_chan.entry_exit = fifo_ff[rd_ptr_ff].entry_exit;
   assign rsp_chan.time_delta = fifo_ff[rd_ptr_ff].time_delta;
   assign rsp_chan.value      = fifo_ff[rd_ptr_ff].value;
   assign rsp_chan.field_index = fifo_ff[rd_ptr_ff].field_index;
   assign rsp_chan.major_tally = fifo_ff[rd_ptr_ff].major_tally;
   assign rsp_chan.rollover   = fifo_ff[rd_ptr_ff].rollover;
   assign rsp_chan.record_end = fifo_ff[rd_ptr_ff].record_end;

endmodule

`default_nettype wire

// ===== hw/rtl/trd_checker.sv =====
`default_nettype none

module trd_sva (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_kind,
   input wire logic [31:0] rsp_minor_code,
   input wire logic        rsp_entry_exit,
   input wire logic [63:0] rsp_time_delta,
   input wire logic [31:0] rsp_value,
   input wire logic [7:0]  rsp_field_index,
   input wire logic [31:0] rsp_major_tally,
   input wire logic        rsp_rollover
);

   // a stalled transaction stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped under stall");

   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != trd_pkg::KIND_HEADER |->
      rsp_time_delta == '0 && rsp_major_tally == '0 && !rsp_rollover)
      else $error("header-only fields set on payload result");

   a_header_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == trd_pkg::KIND_HEADER |->
      rsp_value >= 32'd12 && rsp_value[1:0] == 2'b00 && rsp_field_index == '0 &&
      rsp_major_tally != '0)
      else $error("bad header length, index or tally");

   a_exit_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_exit == rsp_minor_code[31])
      else $error("entry_exit does not follow minor code");

endmodule

bind trace_record_deframer trd_sva u_trd_sva (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_kind        (rsp_chan.kind),
   .rsp_minor_code  (rsp_chan.minor_code),
   .rsp_entry_exit  (rsp_chan.entry_exit),
   .rsp_time_delta  (rsp_chan.time_delta),
   .rsp_value       (rsp_chan.value),
   .rsp_field_index (rsp_chan.field_index),
   .rsp_major_tally (rsp_chan.major_tally),
   .rsp_rollover    (rsp_chan.rollover)
);

`default_nettype wire
